### rtl/cma_pkg.sv
// shared types and constants for the centered moving average unit
// command and status structs between controller and datapath, fsm state codes
// no dependencies
package cma_pkg;

   localparam int HW_W     = 5;
   localparam int HW_RESET = 1;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_PLAN   = 7'b0000010,
      ST_SUM    = 7'b0000100,
      ST_SETTLE = 7'b0001000,
      ST_DLOAD  = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic accept;
      logic plan;
      logic read;
      logic div_load;
      logic div_step;
      logic emit;
      logic next_e;
      logic seq_clear;
   } cmd_type;

   typedef struct packed {
      logic emit_needed;
      logic sum_done;
      logic div_done;
      logic out_free;
      logic more_windows;
      logic seq_last;
   } status_type;

endpackage

### rtl/cma_ctrl.sv
// controller fsm for the centered moving average unit
// sequences window planning, summation, division and result emission
// depends on cma_pkg
module cma_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  cma_pkg::status_type    status,
   output cma_pkg::cmd_type       cmd
);

   cma_pkg::state_type state_ff;
   cma_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cma_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == cma_pkg::ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         cma_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = cma_pkg::ST_PLAN;
            end
         end
         cma_pkg::ST_PLAN: begin
            cmd.plan = 1'b1;
            state_in = status.emit_needed ? cma_pkg::ST_SUM : cma_pkg::ST_IDLE;
         end
         cma_pkg::ST_SUM: begin
            cmd.read = 1'b1;
            if (status.sum_done) begin
               state_in = cma_pkg::ST_SETTLE;
            end
         end
         cma_pkg::ST_SETTLE: begin
            state_in = cma_pkg::ST_DLOAD;
         end
         cma_pkg::ST_DLOAD: begin
            cmd.div_load = 1'b1;
            state_in     = cma_pkg::ST_DIV;
         end
         cma_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = cma_pkg::ST_EMIT;
            end
         end
         cma_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.more_windows) begin
                  cmd.next_e = 1'b1;
                  state_in   = cma_pkg::ST_PLAN;
               end else begin
                  cmd.seq_clear = status.seq_last;
                  state_in      = cma_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = cma_pkg::ST_IDLE;
         end
      endcase
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state register not one-hot");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded while output register busy");

   a_accept_plan: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == cma_pkg::ST_PLAN)
      else $error("accepted beat not followed by planning");

   a_clear_final: assert property (@(posedge clock) disable iff (reset)
      cmd.seq_clear |-> (cmd.emit && !status.more_windows))
      else $error("sequence cleared before final average");

endmodule

### rtl/cma_datapath.sv
// datapath for the centered moving average unit
// sample ring memory, window accumulator, restoring divider, output register
// depends on cma_pkg; driven by cma_ctrl commands
module cma_datapath #(
   parameter int MAX_HALF_WIDTH = 16,
   parameter int SAMPLE_BITS    = 16,
   parameter int TDATA_W        = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wen,
   input  logic [cma_pkg::HW_W-1:0]    csr_wdata,
   input  logic [SAMPLE_BITS-1:0]      sample,
   input  logic                        is_last,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output logic [TDATA_W-1:0]          rsp_tdata,
   output logic                        rsp_tlast,
   input  cma_pkg::cmd_type            cmd,
   output cma_pkg::status_type         status
);

   localparam int RING   = 2 * MAX_HALF_WIDTH + 1;
   localparam int PTR_W  = $clog2(RING);
   localparam int CNT_W  = $clog2(RING + 1);
   localparam int K_W    = $clog2(MAX_HALF_WIDTH + 1);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(RING);
   localparam int DC_W   = $clog2(SUM_W);

   logic signed [SAMPLE_BITS-1:0] ring_mem [RING];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   logic [cma_pkg::HW_W-1:0] hw_ff, hw_in;
   logic [PTR_W-1:0]         wp_ff, wp_in;
   logic [CNT_W-1:0]         rc_ff, rc_in;
   logic                     acc_en_ff, acc_en_in;
   logic                     out_valid_ff, out_valid_in;

   logic [K_W-1:0]            k_ff;
   logic [PTR_W-1:0]          e_ff, nb_ff, hi_ff, d_ff, rp_ff;
   logic                      last_ff;
   logic signed [SUM_W-1:0]   acc_ff;
   logic                      neg_ff;
   logic [SUM_W-1:0]          quo_ff;
   logic [CNT_W-1:0]          rem_ff, divisor_ff;
   logic [DC_W-1:0]           dcnt_ff;
   logic [SAMPLE_BITS-1:0]    out_avg_ff;
   logic                      out_last_ff;

   logic [K_W-1:0]   k_new;
   logic [PTR_W-1:0] nb_new, e_new, k_ext, newest, rp_dec;
   logic [PTR_W:0]   hi_sum;
   logic [PTR_W-1:0] hi_new;
   logic [SUM_W-1:0] acc_abs, quo_signed;
   logic [CNT_W:0]   trial;
   logic             trial_ge;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff        <= cma_pkg::HW_W'(cma_pkg::HW_RESET);
         wp_ff        <= '0;
         rc_ff        <= '0;
         acc_en_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         hw_ff        <= hw_in;
         wp_ff        <= wp_in;
         rc_ff        <= rc_in;
         acc_en_ff    <= acc_en_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign hw_in     = csr_wen ? csr_wdata : hw_ff;
   assign acc_en_in = cmd.read;

   always_comb begin
      wp_in = wp_ff;
      rc_in = rc_ff;
      if (cmd.accept) begin
         wp_in = (wp_ff == PTR_W'(RING - 1)) ? '0 : wp_ff + 1'b1;
         rc_in = (rc_ff < CNT_W'(RING)) ? rc_ff + 1'b1 : rc_ff;
      end else if (cmd.seq_clear) begin
         wp_in = '0;
         rc_in = '0;
      end
   end

   always_comb begin
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // per-beat window planning
   assign k_new  = (int'(hw_ff) > MAX_HALF_WIDTH) ? K_W'(MAX_HALF_WIDTH) : K_W'(hw_ff);
   assign k_ext  = PTR_W'(k_new);
   assign nb_new = (rc_ff < CNT_W'(RING)) ? PTR_W'(rc_ff) : PTR_W'(RING - 1);
   assign e_new  = (is_last && (nb_new < k_ext)) ? nb_new : k_ext;
   assign hi_sum = {1'b0, e_ff} + (PTR_W + 1)'(k_ff);
   assign hi_new = (hi_sum > {1'b0, nb_ff}) ? nb_ff : PTR_W'(hi_sum);
   assign newest = (wp_ff == '0) ? PTR_W'(RING - 1) : wp_ff - 1'b1;
   assign rp_dec = (rp_ff == '0) ? PTR_W'(RING - 1) : rp_ff - 1'b1;

   // ring memory
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ring_mem[wp_ff] <= $signed(sample);
      end
      if (cmd.read) begin
         rd_data_ff <= ring_mem[rp_ff];
      end
   end

   // divider step
   assign acc_abs    = acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);
   assign trial      = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ge   = trial >= {1'b0, divisor_ff};
   assign quo_signed = neg_ff ? SUM_W'(-quo_ff) : quo_ff;

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         k_ff    <= k_new;
         nb_ff   <= nb_new;
         e_ff    <= e_new;
         last_ff <= is_last;
      end else if (cmd.next_e) begin
         e_ff <= e_ff - 1'b1;
      end
      if (cmd.plan) begin
         hi_ff  <= hi_new;
         d_ff   <= '0;
         rp_ff  <= newest;
         acc_ff <= '0;
      end else begin
         if (cmd.read) begin
            d_ff  <= d_ff + 1'b1;
            rp_ff <= rp_dec;
         end
         if (acc_en_ff) begin
            acc_ff <= acc_ff + SUM_W'(rd_data_ff);
         end
      end
      if (cmd.div_load) begin
         neg_ff     <= acc_ff[SUM_W-1];
         quo_ff     <= acc_abs;
         rem_ff     <= '0;
         divisor_ff <= CNT_W'(hi_ff) + 1'b1;
         dcnt_ff    <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= trial_ge ? CNT_W'(trial - {1'b0, divisor_ff}) : CNT_W'(trial);
         quo_ff  <= {quo_ff[SUM_W-2:0], trial_ge};
         dcnt_ff <= dcnt_ff + 1'b1;
      end
      if (cmd.emit) begin
         out_avg_ff  <= quo_signed[SAMPLE_BITS-1:0];
         out_last_ff <= last_ff && (e_ff == '0);
      end
   end

   assign status.emit_needed  = last_ff || (nb_ff >= PTR_W'(k_ff));
   assign status.sum_done     = (d_ff == hi_ff);
   assign status.div_done     = (dcnt_ff == DC_W'(SUM_W - 1));
   assign status.out_free     = !out_valid_ff || rsp_tready;
   assign status.more_windows = last_ff && (e_ff != '0);
   assign status.seq_last     = last_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = TDATA_W'(out_avg_ff);
   assign rsp_tlast  = out_last_ff;

endmodule

### rtl/centered_moving_average_unit.sv
// top level of the centered moving average unit
// joins cma_ctrl and cma_datapath; depends on cma_pkg
//
//   port group   dir   beat contents
//   req_*        in    tdata: sample (low SAMPLE_BITS); tlast: is_last
//   rsp_*        out   tdata: average (low SAMPLE_BITS); tlast: last_out
//   csr_*        in    wdata: half_width, written when csr_wen is high
//
// one input beat at a time; each average is formed by the one-sample-per-cycle
// ring read and the one-bit-per-cycle divider (SAMPLE_BITS + log2 of ring size
// steps); a final beat emits up to k+1 averages
// reset clears the fsm, write pointer, fill count, output valid; half_width goes to 1
// a stalled result waits in the output register while the next beat is accepted
module centered_moving_average_unit #(
   parameter int MAX_HALF_WIDTH = 16,
   parameter int SAMPLE_BITS    = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [cma_pkg::HW_W-1:0]            csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,   // sample
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]    rsp_tdata,   // average
   output logic                                rsp_tlast
);

   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

   cma_pkg::cmd_type    cmd;
   cma_pkg::status_type status;

   cma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cma_datapath #(
      .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
      .SAMPLE_BITS    (SAMPLE_BITS),
      .TDATA_W        (TDATA_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .is_last    (req_tlast),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
